@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the fan duty controller. With SYNTH
// defined the macros expand to nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication: whenever ante holds, cons holds too.
`define TFDC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");
// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define TFDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");
`else
`define TFDC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define TFDC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/tfdc_pkg.sv @@
// ----------------------------------------------------------------------------
// tfdc_pkg
// Widths, codes and transfer payload types of the fan duty controller.
// ----------------------------------------------------------------------------
package tfdc_pkg;

   localparam int CMD_W      = 2;
   localparam int TEMP_W     = 12;
   localparam int KEY_W      = 3;
   localparam int DUTY_W     = 8;
   localparam int MODE_W     = 3;
   localparam int DISP_W     = 3;
   localparam int LOW_W      = 10;
   localparam int HIGH_W     = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [DUTY_W-1:0] DUTY_MIN = 8'd70;
   localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE  = 2'd0,
      CMD_KEY     = 2'd1,
      CMD_TIMEOUT = 2'd2
   } cmd_type;

   typedef enum logic [KEY_W-1:0] {
      KEY_NONE = 3'd0,
      KEY_MENU = 3'd1,
      KEY_INC  = 3'd2,
      KEY_DEC  = 3'd3,
      KEY_AUTO = 3'd4
   } key_type;

   typedef enum logic [DISP_W-1:0] {
      DISP_NONE    = 3'd0,
      DISP_TEMP    = 3'd1,
      DISP_THRESH  = 3'd2,
      DISP_PERCENT = 3'd3,
      DISP_FAULT   = 3'd4
   } disp_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_INIT  = 2'd0,
      CSR_HIGH_INIT = 2'd1,
      CSR_DUTY_INIT = 2'd2
   } csr_index_type;

   // Mode codes as they appear on the result channel.
   localparam logic [MODE_W-1:0] MODE_OPERATE    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LOW_SETUP  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_HIGH_SETUP = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DUTY_SETUP = 3'd3;
   localparam logic [MODE_W-1:0] MODE_FAULT      = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic signed [TEMP_W-1:0] temperature;
      logic                     sensor_present;
      logic [KEY_W-1:0]         key_code;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0]        duty;
      logic                     fan_enable;
      logic [MODE_W-1:0]        mode;
      logic                     auto_on;
      logic signed [TEMP_W-1:0] display_value;
      logic [DISP_W-1:0]        display_kind;
      logic                     store_low;
      logic                     store_high;
      logic [LOW_W-1:0]         low_threshold;
      logic [HIGH_W-1:0]        high_threshold;
   } rsp_type;

   typedef struct packed {
      logic                  valid;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_wr_type;

endpackage

@@ rtl/core/tfdc_if.sv @@
// ----------------------------------------------------------------------------
// tfdc channel interfaces
// Valid/ready channels for event input, result output and register writes.
// ----------------------------------------------------------------------------
interface tfdc_req_if;
   import tfdc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         cmd;
   logic signed [TEMP_W-1:0] temperature;
   logic                     sensor_present;
   logic [KEY_W-1:0]         key_code;

   modport source (output valid, cmd, temperature, sensor_present, key_code, input ready);
   modport sink (input valid, cmd, temperature, sensor_present, key_code, output ready);
endinterface

interface tfdc_rsp_if;
   import tfdc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [DUTY_W-1:0]        duty;
   logic                     fan_enable;
   logic [MODE_W-1:0]        mode;
   logic                     auto_on;
   logic signed [TEMP_W-1:0] display_value;
   logic [DISP_W-1:0]        display_kind;
   logic                     store_low;
   logic                     store_high;
   logic [LOW_W-1:0]         low_threshold;
   logic [HIGH_W-1:0]        high_threshold;

   modport source (output valid, duty, fan_enable, mode, auto_on, display_value,
                   display_kind, store_low, store_high, low_threshold, high_threshold,
                   input ready);
   modport sink (input valid, duty, fan_enable, mode, auto_on, display_value,
                 display_kind, store_low, store_high, low_threshold, high_threshold,
                 output ready);
endinterface

interface tfdc_csr_if;
   import tfdc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/tfdc_curve.sv @@
// ----------------------------------------------------------------------------
// tfdc_curve
// Automatic duty curve: splits the threshold span into equal steps and maps
// a temperature inside the span to level squared plus the minimum duty.
// ----------------------------------------------------------------------------
module tfdc_curve #(
   parameter int NUM_LEVELS = 11
) (
   input  logic signed [tfdc_pkg::TEMP_W-1:0] temp_i,
   input  logic [tfdc_pkg::LOW_W-1:0]         low_i,
   input  logic [tfdc_pkg::HIGH_W-1:0]        high_i,
   input  logic [tfdc_pkg::DUTY_W-1:0]        duty_i,
   output logic [tfdc_pkg::DUTY_W-1:0]        duty_o
);
   import tfdc_pkg::*;

   localparam int STEPS   = NUM_LEVELS - 1;
   // Exact floor division by STEPS for any span below 2**HIGH_W.
   localparam int SHIFT   = HIGH_W + $clog2(STEPS);
   localparam int RECIP   = ((2 ** SHIFT) + STEPS - 1) / STEPS;
   localparam int RECIP_W = SHIFT + 1;
   localparam int PROD_W  = HIGH_W + RECIP_W;
   localparam int POS_W   = $clog2(NUM_LEVELS);
   localparam int SCL_W   = HIGH_W + POS_W;
   localparam int CMP_W   = SCL_W + 2;
   localparam int CURVE_W = ((2 * POS_W > DUTY_W) ? 2 * POS_W : DUTY_W) + 1;

   logic [HIGH_W-1:0]       span;
   logic [PROD_W-1:0]       prod;
   logic [HIGH_W-1:0]       step;
   logic signed [CMP_W-1:0] temp_ext;
   logic signed [CMP_W-1:0] low_ext;
   logic signed [CMP_W-1:0] high_ext;
   logic [NUM_LEVELS-1:1]   hits;
   logic [POS_W-1:0]        pos;
   logic [CURVE_W-1:0]      level_duty;
   logic [DUTY_W-1:0]       level_sat;

   // The caller guarantees high_i above low_i, so the span is positive.
   assign span = high_i - HIGH_W'(low_i);
   assign prod = PROD_W'(span) * PROD_W'(RECIP);
   assign step = prod[SHIFT +: HIGH_W];

   assign temp_ext = CMP_W'(temp_i);
   assign low_ext  = $signed(CMP_W'(low_i));
   assign high_ext = $signed(CMP_W'(high_i));

   // One comparator lane per inner level boundary; the top level always hits.
   for (genvar k = 1; k < NUM_LEVELS - 1; k++) begin : g_lane
      logic [SCL_W-1:0]        scaled;
      logic signed [CMP_W-1:0] bound;

      assign scaled  = SCL_W'(step) * SCL_W'(k);
      assign bound   = $signed(CMP_W'(scaled)) + low_ext;
      assign hits[k] = temp_ext <= bound;
   end
   assign hits[NUM_LEVELS-1] = 1'b1;

   always_comb begin
      pos = POS_W'(NUM_LEVELS - 1);
      for (int k = NUM_LEVELS - 2; k >= 1; k--) begin
         if (hits[k]) begin
            pos = POS_W'(k);
         end
      end
   end

   assign level_duty = CURVE_W'(pos) * CURVE_W'(pos) + CURVE_W'(DUTY_MIN);
   assign level_sat  = (level_duty > CURVE_W'(DUTY_MAX)) ? DUTY_MAX : level_duty[DUTY_W-1:0];

   always_comb begin
      priority if (temp_ext > high_ext) begin
         duty_o = DUTY_MAX;
      end else if (temp_ext < low_ext) begin
         duty_o = DUTY_MIN;
      end else if (temp_ext == low_ext) begin
         duty_o = duty_i;
      end else begin
         duty_o = level_sat;
      end
   end

endmodule

@@ rtl/core/tfdc_ctrl.sv @@
// ----------------------------------------------------------------------------
// tfdc_ctrl
// Menu mode machine, threshold and duty state, and the registered result of
// each processed event.
// ----------------------------------------------------------------------------
module tfdc_ctrl #(
   parameter int NUM_LEVELS = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  tfdc_pkg::req_type      req_i,
   input  tfdc_pkg::csr_wr_type   csr_i,
   output tfdc_pkg::rsp_type      rsp_o
);
   import tfdc_pkg::*;

   typedef enum logic [MODE_W-1:0] {
      ST_OPERATE = MODE_OPERATE,
      ST_LOW     = MODE_LOW_SETUP,
      ST_HIGH    = MODE_HIGH_SETUP,
      ST_DUTY    = MODE_DUTY_SETUP,
      ST_FAULT   = MODE_FAULT
   } state_type;

   localparam logic [LOW_W-1:0]  LOW_RESET    = 10'd220;
   localparam logic [HIGH_W-1:0] HIGH_RESET   = 11'd280;
   localparam logic [DUTY_W-1:0] MANUAL_RESET = 8'd127;
   localparam logic [DUTY_W-1:0] DUTY_RESET   = 8'd80;
   localparam logic [HIGH_W-1:0] HIGH_GAP     = 11'd50;
   localparam logic [HIGH_W-1:0] THR_STEP     = 11'd10;
   localparam logic [HIGH_W-1:0] LIMIT_MAX    = 11'd1000;
   localparam logic [DUTY_W-1:0] DUTY_STEP    = 8'd5;

   // Percent = (54*d - 3800) / 100, done as one multiply by 54*5243 with the
   // offset 3800*5243 folded in, then a shift by 19 (exact below 10000).
   localparam int PCT_W      = 7;
   localparam int PCT_PROD_W = 27;
   localparam int PCT_SHIFT  = 19;
   localparam int PCT_RECIP  = 283122;
   localparam int PCT_BIAS   = 19923400;

   function automatic logic [PCT_W-1:0] duty_percent(input logic [DUTY_W-1:0] d);
      logic [PCT_PROD_W-1:0] scaled;
      scaled = PCT_PROD_W'(d) * PCT_PROD_W'(PCT_RECIP) - PCT_PROD_W'(PCT_BIAS);
      return (d > DUTY_MIN) ? scaled[PCT_SHIFT +: PCT_W] : '0;
   endfunction

   function automatic logic [HIGH_W-1:0] thr_adjust(input logic [HIGH_W-1:0] v,
                                                    input logic up);
      logic [HIGH_W-1:0] res;
      if (up) begin
         res = (v + THR_STEP >= LIMIT_MAX) ? LIMIT_MAX : v + THR_STEP;
      end else begin
         res = (v < THR_STEP) ? '0 : v - THR_STEP;
      end
      return res;
   endfunction

   state_type                state_ff, state_in;
   logic                     auto_ff, auto_in;
   logic [LOW_W-1:0]         low_ff, low_in;
   logic [HIGH_W-1:0]        high_ff, high_in;
   logic signed [TEMP_W-1:0] cur_temp_ff, cur_temp_in;
   logic signed [TEMP_W-1:0] prev_temp_ff, prev_temp_in;
   logic [DUTY_W-1:0]        manual_ff, manual_in;
   logic [DUTY_W-1:0]        duty_ff, duty_in;
   logic                     fan_ff, fan_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     is_key;
   logic                     adj;
   logic                     key_up;
   logic signed [TEMP_W-1:0] ctl_temp;
   logic                     high_wrap;
   logic [HIGH_W-1:0]        high_fix;
   logic signed [TEMP_W-1:0] low_s;
   logic signed [TEMP_W-1:0] high_s;
   logic [DUTY_W-1:0]        curve_duty;
   logic [DUTY_W-1:0]        ctl_pick;
   logic                     ctl_fan;
   logic [DUTY_W:0]          duty_sum;
   logic [DUTY_W-1:0]        duty_up;
   logic [DUTY_W-1:0]        duty_down;
   logic                     run_ctl;
   logic                     st_low;
   logic                     st_high;
   logic [DISP_W-1:0]        disp_kind;
   logic signed [TEMP_W-1:0] disp_val;

   assign is_key = req_i.cmd == CMD_KEY;
   assign adj    = is_key && (req_i.key_code == KEY_INC || req_i.key_code == KEY_DEC);
   assign key_up = req_i.key_code == KEY_INC;

   // Temperature that the fan control step sees: a valid sample taken in
   // operate or fault mode replaces the stored one first.
   always_comb begin
      ctl_temp = cur_temp_ff;
      if (req_i.cmd == CMD_SAMPLE && req_i.sensor_present &&
          (state_ff == ST_OPERATE || state_ff == ST_FAULT)) begin
         ctl_temp = req_i.temperature;
      end
   end

   assign high_wrap = high_ff <= HIGH_W'(low_ff);
   assign high_fix  = high_wrap ? HIGH_W'(low_ff) + HIGH_GAP : high_ff;
   assign low_s     = $signed(TEMP_W'(low_ff));
   assign high_s    = $signed(TEMP_W'(high_fix));

   tfdc_curve #(
      .NUM_LEVELS (NUM_LEVELS)
   ) u_curve (
      .temp_i (ctl_temp),
      .low_i  (low_ff),
      .high_i (high_fix),
      .duty_i (duty_ff),
      .duty_o (curve_duty)
   );

   always_comb begin
      priority if (ctl_temp == prev_temp_ff) begin
         ctl_pick = duty_ff;
      end else if (auto_ff) begin
         ctl_pick = curve_duty;
      end else if (ctl_temp < low_s) begin
         ctl_pick = DUTY_MIN;
      end else if (ctl_temp > high_s) begin
         ctl_pick = DUTY_MAX;
      end else begin
         ctl_pick = manual_ff;
      end
   end
   assign ctl_fan = ctl_pick > DUTY_MIN;

   assign duty_sum  = (DUTY_W+1)'(manual_ff) + (DUTY_W+1)'(DUTY_STEP);
   assign duty_up   = (duty_sum >= (DUTY_W+1)'(DUTY_MAX)) ? DUTY_MAX : duty_sum[DUTY_W-1:0];
   assign duty_down = (manual_ff <= DUTY_MIN + DUTY_STEP) ? DUTY_MIN : manual_ff - DUTY_STEP;

   always_comb begin
      state_in     = state_ff;
      auto_in      = auto_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      cur_temp_in  = cur_temp_ff;
      prev_temp_in = prev_temp_ff;
      manual_in    = manual_ff;
      duty_in      = duty_ff;
      fan_in       = fan_ff;
      run_ctl      = 1'b0;
      st_low       = 1'b0;
      st_high      = 1'b0;
      disp_kind    = DISP_NONE;
      disp_val     = '0;

      unique case (state_ff)
         ST_OPERATE: begin
            if (req_i.cmd == CMD_SAMPLE && !req_i.sensor_present) begin
               state_in  = ST_FAULT;
               duty_in   = '0;
               fan_in    = 1'b0;
               disp_kind = DISP_FAULT;
            end else begin
               if (req_i.cmd == CMD_SAMPLE) begin
                  cur_temp_in = req_i.temperature;
                  disp_kind   = DISP_TEMP;
                  disp_val    = req_i.temperature;
               end
               run_ctl = 1'b1;
               if (is_key) begin
                  unique case (req_i.key_code)
                     KEY_MENU: begin
                        state_in  = ST_LOW;
                        disp_kind = DISP_THRESH;
                        disp_val  = $signed(TEMP_W'(low_ff));
                     end
                     KEY_AUTO: begin
                        auto_in = !auto_ff;
                     end
                     KEY_INC, KEY_DEC: begin
                        if (!auto_ff) begin
                           state_in  = ST_DUTY;
                           disp_kind = DISP_PERCENT;
                           disp_val  = $signed(TEMP_W'(duty_percent(manual_ff)));
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
         ST_LOW: begin
            if (req_i.cmd == CMD_TIMEOUT) begin
               st_low   = 1'b1;
               state_in = ST_OPERATE;
               run_ctl  = 1'b1;
            end else if (is_key && req_i.key_code == KEY_MENU) begin
               st_low    = 1'b1;
               state_in  = ST_HIGH;
               disp_kind = DISP_THRESH;
               disp_val  = $signed(TEMP_W'(high_ff));
            end else if (is_key) begin
               if (adj) begin
                  low_in = LOW_W'(thr_adjust(HIGH_W'(low_ff), key_up));
               end
               disp_kind = DISP_THRESH;
               disp_val  = $signed(TEMP_W'(low_in));
            end
         end
         ST_HIGH: begin
            if (req_i.cmd == CMD_TIMEOUT || (is_key && req_i.key_code == KEY_MENU)) begin
               st_high  = 1'b1;
               state_in = ST_OPERATE;
               run_ctl  = 1'b1;
            end else if (is_key) begin
               if (adj) begin
                  high_in = thr_adjust(high_ff, key_up);
               end
               disp_kind = DISP_THRESH;
               disp_val  = $signed(TEMP_W'(high_in));
            end
         end
         ST_DUTY: begin
            if (req_i.cmd == CMD_TIMEOUT) begin
               state_in = ST_OPERATE;
               run_ctl  = 1'b1;
            end else if (is_key) begin
               if (req_i.key_code == KEY_INC) begin
                  manual_in = duty_up;
                  duty_in   = duty_up;
               end else if (req_i.key_code == KEY_DEC) begin
                  manual_in = duty_down;
                  duty_in   = duty_down;
               end
               disp_kind = DISP_PERCENT;
               disp_val  = $signed(TEMP_W'(duty_percent(manual_in)));
            end
         end
         ST_FAULT: begin
            if (req_i.cmd == CMD_SAMPLE && req_i.sensor_present) begin
               cur_temp_in = req_i.temperature;
               disp_kind   = DISP_TEMP;
               disp_val    = req_i.temperature;
               state_in    = ST_OPERATE;
               run_ctl     = 1'b1;
            end
         end
         default: begin
            state_in = ST_FAULT;
         end
      endcase

      // Fan control step: repair an inverted threshold pair, follow a changed
      // temperature, and switch the fan off at or below the minimum duty.
      if (run_ctl) begin
         high_in      = high_fix;
         st_high      = st_high | high_wrap;
         prev_temp_in = ctl_temp;
         fan_in       = ctl_fan;
         duty_in      = ctl_fan ? ctl_pick : '0;
      end

      rsp_in.duty           = fan_in ? duty_in : '0;
      rsp_in.fan_enable     = fan_in;
      rsp_in.mode           = state_in;
      rsp_in.auto_on        = auto_in;
      rsp_in.display_value  = disp_val;
      rsp_in.display_kind   = disp_kind;
      rsp_in.store_low      = st_low;
      rsp_in.store_high     = st_high;
      rsp_in.low_threshold  = low_in;
      rsp_in.high_threshold = high_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_OPERATE;
         auto_ff      <= 1'b1;
         low_ff       <= LOW_RESET;
         high_ff      <= HIGH_RESET;
         cur_temp_ff  <= '0;
         prev_temp_ff <= '0;
         manual_ff    <= MANUAL_RESET;
         duty_ff      <= DUTY_RESET;
         fan_ff       <= 1'b1;
      end else if (step_en) begin
         state_ff     <= state_in;
         auto_ff      <= auto_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         cur_temp_ff  <= cur_temp_in;
         prev_temp_ff <= prev_temp_in;
         manual_ff    <= manual_in;
         duty_ff      <= duty_in;
         fan_ff       <= fan_in;
      end else if (csr_i.valid) begin
         unique case (csr_i.index)
            CSR_LOW_INIT:  low_ff    <= csr_i.data[LOW_W-1:0];
            CSR_HIGH_INIT: high_ff   <= HIGH_W'(csr_i.data);
            CSR_DUTY_INIT: manual_ff <= csr_i.data[DUTY_W-1:0];
            default: ;
         endcase
      end
      if (step_en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_o = rsp_ff;

endmodule

@@ rtl/core/temperature_fan_duty_controller_top.sv @@
// ----------------------------------------------------------------------------
// temperature_fan_duty_controller_top
// Fan duty controller with a small threshold and duty menu.
//
// Events (temperature samples, key presses, menu timeouts) arrive on req_ch;
// each accepted transfer produces exactly one result transfer on rsp_ch with
// the fan drive, the mode, the display request and the threshold values.
// The block processes one event per clock while rsp_ch does not stall. An
// event is held in the input register, then the mode logic and the duty
// curve update the state and load the result register, from which the
// result is offered on rsp_ch. If rsp_ch stalls, the result register holds
// and the input register still takes one more event; req_ch.ready drops
// only when both are full. csr_ch writes the threshold and manual duty
// registers and is always ready; write it only while idle.
// Synchronous reset returns operate mode, automatic curve, thresholds
// 22.0 and 28.0 degrees, manual duty 127, duty 80 with the fan driven.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module temperature_fan_duty_controller_top #(
   parameter int NUM_LEVELS = 11
) (
   input logic        clock,
   input logic        reset,
   tfdc_req_if.sink   req_ch,
   tfdc_rsp_if.source rsp_ch,
   tfdc_csr_if.sink   csr_ch
);
   import tfdc_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic       out_valid_ff, out_valid_in;
   req_type    req_ff;
   logic       advance;
   logic       step_en;
   logic       req_fire;
   csr_wr_type csr_wr;
   rsp_type    rsp;

   // The result register can take a new result when it is empty or being
   // drained this cycle; the event in the input register is processed then.
   assign advance  = !out_valid_ff || rsp_ch.ready;
   assign step_en  = in_valid_ff && advance;
   assign req_fire = req_ch.valid && req_ch.ready;

   // The input register accepts whenever it is empty or moving on.
   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step_en) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (step_en) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_fire) begin
         req_ff.cmd            <= req_ch.cmd;
         req_ff.temperature    <= req_ch.temperature;
         req_ff.sensor_present <= req_ch.sensor_present;
         req_ff.key_code       <= req_ch.key_code;
      end
   end

   // Register writes are accepted in every cycle; a write in a cycle that processes an event is lost.
   assign csr_ch.ready = 1'b1;
   assign csr_wr.valid = csr_ch.valid;
   assign csr_wr.index = csr_ch.index;
   assign csr_wr.data  = csr_ch.data;

   tfdc_ctrl #(
      .NUM_LEVELS (NUM_LEVELS)
   ) u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .req_i   (req_ff),
      .csr_i   (csr_wr),
      .rsp_o   (rsp)
   );

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.duty           = rsp.duty;
   assign rsp_ch.fan_enable     = rsp.fan_enable;
   assign rsp_ch.mode           = rsp.mode;
   assign rsp_ch.auto_on        = rsp.auto_on;
   assign rsp_ch.display_value  = rsp.display_value;
   assign rsp_ch.display_kind   = rsp.display_kind;
   assign rsp_ch.store_low      = rsp.store_low;
   assign rsp_ch.store_high     = rsp.store_high;
   assign rsp_ch.low_threshold  = rsp.low_threshold;
   assign rsp_ch.high_threshold = rsp.high_threshold;

   // A processed event always shows up as a pending result.
   `TFDC_ASSERT_NEXT(a_step_loads_result, clock, reset, step_en, out_valid_ff)
   // Input back-pressure only arises with both stages full and a stalled sink.
   `TFDC_ASSERT_IMPLIES(a_stall_only_when_full, clock, reset, !req_ch.ready, in_valid_ff && out_valid_ff && !rsp_ch.ready)
   // A drained result with nothing behind it leaves the output empty.
   `TFDC_ASSERT_NEXT(a_result_drains, clock, reset, out_valid_ff && rsp_ch.ready && !step_en, !out_valid_ff)
   // Fault mode never drives the fan.
   `TFDC_ASSERT_IMPLIES(a_fault_fan_off, clock, reset, out_valid_ff && rsp_ch.mode == MODE_FAULT, !rsp_ch.fan_enable)
   // Duty setup is reachable only in manual mode and cannot leave it.
   `TFDC_ASSERT_IMPLIES(a_duty_setup_manual, clock, reset, out_valid_ff && rsp_ch.mode == MODE_DUTY_SETUP, !rsp_ch.auto_on)

endmodule
